[src/mtft_pkg.sv]
// Shared types and constants of the multi-turn motor feedback tracker.
package mtft_pkg;

    localparam int HALF_TURN      = 4096;
    localparam int FULL_TURN      = 8192;
    localparam int ANGLE_LSB_MULT = 45;
    // speed / 100 as (|speed| * 5243) >> 19, exact for |speed| <= 43690
    localparam int SPEED_RECIP    = 5243;
    localparam int SPEED_SHIFT    = 19;

    localparam int ANGLE_W = 13;
    localparam int ERR_W   = 14;
    localparam int REL_W   = 19;
    localparam int TURNS_W = 32;
    localparam int SPEED_W = 16;
    localparam int SPD_W   = 10;
    localparam int CURR_W  = 16;
    localparam int TEMP_W  = 8;

    typedef enum logic [1:0] {
        TURN_HOLD,
        TURN_UP,
        TURN_DOWN
    } t_turn_op;

    // word handed from the front to the back
    typedef struct packed {
        t_turn_op                   turn_op;
        logic signed [ERR_W-1:0]    err;
        logic        [ANGLE_W-1:0]  angle;
        logic signed [SPD_W-1:0]    spd;
        logic signed [CURR_W-1:0]   current;
        logic        [TEMP_W-1:0]   coil;
        logic        [TEMP_W-1:0]   mos;
    } t_job;

    // result word
    typedef struct packed {
        logic signed [REL_W-1:0]    rel;
        logic signed [TURNS_W-1:0]  turns;
        logic signed [TURNS_W-1:0]  multi;
        logic signed [SPD_W-1:0]    spd;
        logic signed [CURR_W-1:0]   current;
        logic        [TEMP_W-1:0]   coil;
        logic        [TEMP_W-1:0]   mos;
    } t_result;

    // handshake state of a queue as seen by its neighbour
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[src/mtft_fifo.sv]
// Small first-word-fall-through queue of words.
module mtft_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output mtft_pkg::t_q_stat o_stat
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               do_push, do_pop;

    assign o_stat.full  = (r_count == COUNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + COUNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/mtft_front.sv]
// Front end: takes a feedback frame, classifies the turn step and scales the speed.
module mtft_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mtft_pkg::ANGLE_W-1:0]        i_cfg_wdata,
    input  logic                                i_accept,
    input  logic [mtft_pkg::ANGLE_W-1:0]        i_encoder_angle,
    input  logic signed [mtft_pkg::SPEED_W-1:0] i_speed_raw,
    input  logic signed [mtft_pkg::CURR_W-1:0]  i_current_raw,
    input  logic [mtft_pkg::TEMP_W-1:0]         i_coil_temp,
    input  logic [mtft_pkg::TEMP_W-1:0]         i_mos_temp,
    output mtft_pkg::t_job                      o_job
);

    localparam int ERR_W = mtft_pkg::ERR_W;
    localparam int MAG_W = mtft_pkg::SPEED_W + 1;
    localparam int PROD_W = MAG_W + 13;
    localparam int SPD_W = mtft_pkg::SPD_W;

    logic [mtft_pkg::ANGLE_W-1:0] r_zero_offset;
    logic [mtft_pkg::ANGLE_W-1:0] r_prev_angle;

    logic signed [ERR_W-1:0] diff, err_raw, err;
    logic [MAG_W-1:0]        spd_ext, mag;
    logic [PROD_W-1:0]       prod;
    logic [SPD_W-1:0]        quot;
    mtft_pkg::t_turn_op      turn_op;

    always_comb begin
        diff    = $signed({1'b0, i_encoder_angle}) - $signed({1'b0, r_prev_angle});
        err_raw = $signed({1'b0, i_encoder_angle}) - $signed({1'b0, r_zero_offset});

        // a wrap past zero shows as a jump of more than half a turn
        if (diff < -mtft_pkg::HALF_TURN) begin
            turn_op = mtft_pkg::TURN_UP;
        end else if (diff > mtft_pkg::HALF_TURN) begin
            turn_op = mtft_pkg::TURN_DOWN;
        end else begin
            turn_op = mtft_pkg::TURN_HOLD;
        end

        if (err_raw > mtft_pkg::HALF_TURN) begin
            err = err_raw - ERR_W'(mtft_pkg::FULL_TURN);
        end else if (err_raw < -mtft_pkg::HALF_TURN) begin
            err = err_raw + ERR_W'(mtft_pkg::FULL_TURN);
        end else begin
            err = err_raw;
        end

        // divide the magnitude, then restore the sign: truncates toward zero
        spd_ext = {i_speed_raw[mtft_pkg::SPEED_W-1], i_speed_raw};
        mag     = i_speed_raw[mtft_pkg::SPEED_W-1] ? (~spd_ext + MAG_W'(1)) : spd_ext;
        prod    = PROD_W'(mag) * PROD_W'(mtft_pkg::SPEED_RECIP);
        quot    = prod[mtft_pkg::SPEED_SHIFT +: SPD_W];

        o_job.turn_op = turn_op;
        o_job.err     = err;
        o_job.angle   = i_encoder_angle;
        o_job.spd     = i_speed_raw[mtft_pkg::SPEED_W-1] ? $signed(~quot + SPD_W'(1))
                                                         : $signed(quot);
        o_job.current = i_current_raw;
        o_job.coil    = i_coil_temp;
        o_job.mos     = i_mos_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
            r_prev_angle  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_zero_offset <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_prev_angle <= i_encoder_angle;
            end
        end
    end

endmodule

[src/mtft_back.sv]
// Back end: applies the turn step and builds the result word.
module mtft_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtft_pkg::t_job    i_job,
    input  mtft_pkg::t_q_stat i_job_stat,
    input  mtft_pkg::t_q_stat i_res_stat,
    output logic              o_job_pop,
    output logic              o_res_push,
    output mtft_pkg::t_result o_result
);

    localparam int TURNS_W = mtft_pkg::TURNS_W;
    localparam int REL_W   = mtft_pkg::REL_W;
    localparam int ERR_W   = mtft_pkg::ERR_W;

    logic signed [TURNS_W-1:0] r_turns, n_turns;
    logic signed [REL_W-1:0]   err_ext;
    logic                      advance;

    assign advance    = !i_job_stat.empty && !i_res_stat.full;
    assign o_job_pop  = advance;
    assign o_res_push = advance;

    always_comb begin
        case (i_job.turn_op)
            mtft_pkg::TURN_UP:   n_turns = r_turns + TURNS_W'(1);
            mtft_pkg::TURN_DOWN: n_turns = r_turns - TURNS_W'(1);
            default:             n_turns = r_turns;
        endcase
    end

    always_comb begin
        err_ext = $signed({{(REL_W - ERR_W){i_job.err[ERR_W-1]}}, i_job.err});

        o_result.rel     = REL_W'(err_ext * REL_W'(mtft_pkg::ANGLE_LSB_MULT));
        o_result.turns   = n_turns;
        // turns * 8192 + angle is a plain concatenation, angle being below 8192
        o_result.multi   = $signed({n_turns[TURNS_W-mtft_pkg::ANGLE_W-1:0], i_job.angle});
        o_result.spd     = i_job.spd;
        o_result.current = i_job.current;
        o_result.coil    = i_job.coil;
        o_result.mos     = i_job.mos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turns <= '0;
        end else if (advance) begin
            r_turns <= n_turns;
        end
    end

endmodule

[src/multi_turn_motor_feedback_tracker_unit.sv]
// Top level of the multi-turn motor feedback tracker.
//
//  channel  | handshake           | word
//  ---------+---------------------+-------------------------------------------
//  frame in | push / full         | encoder angle, speed, current, temps
//  result   | empty / pop         | rel. angle, turns, multi-turn, speed/100 ..
//  config   | i_cfg_we            | zero offset (13 bit)
//
// One frame a cycle sustained while the result side keeps popping; a pushed frame
// reaches the result ports through the registered job queue and the result queue.
// Reset is synchronous and clears the offset, previous angle, turn count and queues.
// A stalled result side fills the result queue, then the job queue, then raises full.
module multi_turn_motor_feedback_tracker_unit #(
    parameter int JOB_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mtft_pkg::ANGLE_W-1:0]        i_cfg_wdata,
    input  logic                                push,
    output logic                                full,
    input  logic [mtft_pkg::ANGLE_W-1:0]        i_encoder_angle,
    input  logic signed [mtft_pkg::SPEED_W-1:0] i_speed_raw,
    input  logic signed [mtft_pkg::CURR_W-1:0]  i_current_raw,
    input  logic [mtft_pkg::TEMP_W-1:0]         i_coil_temp,
    input  logic [mtft_pkg::TEMP_W-1:0]         i_mos_temp,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [mtft_pkg::REL_W-1:0]   o_relative_angle,
    output logic signed [mtft_pkg::TURNS_W-1:0] o_turn_count,
    output logic signed [mtft_pkg::TURNS_W-1:0] o_multi_turn_angle,
    output logic signed [mtft_pkg::SPD_W-1:0]   o_speed_scaled,
    output logic signed [mtft_pkg::CURR_W-1:0]  o_current_out,
    output logic [mtft_pkg::TEMP_W-1:0]         o_coil_temp_out,
    output logic [mtft_pkg::TEMP_W-1:0]         o_mos_temp_out
);

    localparam int JOB_W = $bits(mtft_pkg::t_job);
    localparam int RES_W = $bits(mtft_pkg::t_result);

    mtft_pkg::t_job    front_job, back_job;
    mtft_pkg::t_result back_result, head_result;
    mtft_pkg::t_q_stat job_stat, res_stat;
    logic              accept, job_pop, res_push;
    logic [JOB_W-1:0]  job_rd;
    logic [RES_W-1:0]  res_rd;

    assign full   = job_stat.full;
    assign empty  = res_stat.empty;
    assign accept = push && !job_stat.full;

    mtft_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_encoder_angle (i_encoder_angle),
        .i_speed_raw     (i_speed_raw),
        .i_current_raw   (i_current_raw),
        .i_coil_temp     (i_coil_temp),
        .i_mos_temp      (i_mos_temp),
        .o_job           (front_job)
    );

    mtft_fifo #(
        .DATA_W (JOB_W),
        .DEPTH  (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_job),
        .i_pop   (job_pop),
        .o_data  (job_rd),
        .o_stat  (job_stat)
    );

    assign back_job = mtft_pkg::t_job'(job_rd);

    mtft_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (back_job),
        .i_job_stat (job_stat),
        .i_res_stat (res_stat),
        .o_job_pop  (job_pop),
        .o_res_push (res_push),
        .o_result   (back_result)
    );

    mtft_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .i_pop   (pop),
        .o_data  (res_rd),
        .o_stat  (res_stat)
    );

    assign head_result        = mtft_pkg::t_result'(res_rd);
    assign o_relative_angle   = head_result.rel;
    assign o_turn_count       = head_result.turns;
    assign o_multi_turn_angle = head_result.multi;
    assign o_speed_scaled     = head_result.spd;
    assign o_current_out      = head_result.current;
    assign o_coil_temp_out    = head_result.coil;
    assign o_mos_temp_out     = head_result.mos;

endmodule

[src/mtft_checker.sv]
// Port-level checks of the tracker and their binding to the top level.
module mtft_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                full,
    input  logic                                empty,
    input  logic                                pop,
    input  logic signed [mtft_pkg::REL_W-1:0]   o_relative_angle,
    input  logic signed [mtft_pkg::TURNS_W-1:0] o_turn_count,
    input  logic signed [mtft_pkg::TURNS_W-1:0] o_multi_turn_angle
);

    localparam int LOW_W = mtft_pkg::TURNS_W - mtft_pkg::ANGLE_W;

    // out of reset the result queue is empty and the job queue is not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // the job queue can only fill once results back up
    a_full_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input full while no result waits");

    // upper multi-turn bits are the low bits of the turn count
    a_multi_turns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_multi_turn_angle[mtft_pkg::TURNS_W-1:mtft_pkg::ANGLE_W]
                   == o_turn_count[LOW_W-1:0])
        else $error("multi-turn angle disagrees with turn count");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_turn_count) && $stable(o_relative_angle))
        else $error("waiting result word changed");

endmodule

bind multi_turn_motor_feedback_tracker_unit mtft_checker u_mtft_checker (.*);
